/* rtl/core/bmd_pkg.sv */
`default_nettype none

package bmd_pkg;

  // field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TgtW   = 3;
  localparam int unsigned PhysW  = 19;
  localparam int unsigned NibW   = 4;
  localparam int unsigned BankW  = 3;

  // stream widths, whole bytes
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  // decode boundaries
  localparam logic [AddrW-1:0] LatchBase = 16'hF800;
  localparam logic [AddrW-1:0] IoBase    = 16'hF400;
  localparam logic [AddrW-1:0] RomBase   = 16'hC000;

  // bus commands
  typedef enum logic [CmdW-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PORT  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  // access targets
  typedef enum logic [TgtW-1:0] {
    TGT_RAM   = 3'd0,
    TGT_ROM   = 3'd1,
    TGT_LATCH = 3'd2,
    TGT_IO    = 3'd3,
    TGT_ROMWR = 3'd4,
    TGT_NONE  = 3'd5
  } target_t;

  // banking state held by the top level
  typedef struct packed {
    logic [ByteW-1:0] bank_latch;
    logic [BankW-1:0] flat_bank;
    logic             rom_paged_out;
  } bank_state_t;

  // state updates requested by one word
  typedef struct packed {
    logic             latch_we;
    logic [ByteW-1:0] latch_value;
    logic             port_we;
    logic [BankW-1:0] flat_bank;
    logic             rom_paged_out;
  } bank_update_t;

endpackage

`default_nettype wire

/* rtl/core/banked_memory_decoder_core.sv */
// Bus address decoder for a banked 512K RAM board. Each input word is a bus
// read, a bus write or a port A update (cmd in s_tuser); each produces exactly
// one result word naming the target (m_tuser) and physical offset (m_tdata).
// Flat mode (latch_mode 0) uses a 64K bank and ROM-disable bit from port A;
// latch mode (latch_mode 1) uses a bank latch loaded by writes at F800 and up.
// A word is taken every cycle while the output is not stalled: one input
// register, the decode logic, then one output register that presents the result
// word. While a result word waits
// for m_tready the decode stage holds, and only an empty input register still
// takes one more word. Banking state is updated in word order as each word
// passes the decode stage.
// latch_mode may only be written while no words are in flight.

`default_nettype none

module banked_memory_decoder_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_wdata,    // latch_mode
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bmd_pkg::InDataW-1:0]      s_tdata,      // addr, wdata, port_a
  input  wire logic [bmd_pkg::CmdW-1:0]         s_tuser,      // cmd
  // output stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [bmd_pkg::OutDataW-1:0]     m_tdata,      // phys_addr, zero fill
  output logic      [bmd_pkg::TgtW-1:0]         m_tuser       // target
);

  logic                          latch_mode;
  bmd_pkg::bank_state_t          state;

  logic                          in_valid;
  bmd_pkg::cmd_t                 in_cmd;
  logic [bmd_pkg::AddrW-1:0]     in_addr;
  logic [bmd_pkg::ByteW-1:0]     in_wdata;
  logic [bmd_pkg::ByteW-1:0]     in_port_a;

  logic                          out_valid;
  bmd_pkg::target_t              out_target;
  logic [bmd_pkg::PhysW-1:0]     out_phys;

  bmd_pkg::target_t              dec_target;
  logic [bmd_pkg::PhysW-1:0]     dec_phys;
  bmd_pkg::bank_update_t         dec_update;

  logic                          advance;
  logic                          s_accept;

  // handshake
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      latch_mode <= 1'b0;
    end else if (cfg_we) begin
      latch_mode <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_cmd    <= bmd_pkg::cmd_t'(s_tuser);
      in_addr   <= s_tdata[15:0];
      in_wdata  <= s_tdata[23:16];
      in_port_a <= s_tdata[31:24];
    end
  end

  // decode
  bmd_decode u_decode (
    .latch_mode (latch_mode),
    .state      (state),
    .cmd        (in_cmd),
    .addr       (in_addr),
    .wdata      (in_wdata),
    .port_a     (in_port_a),
    .target     (dec_target),
    .phys_addr  (dec_phys),
    .update     (dec_update)
  );

  // banking state, updated as each word leaves the decode stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_valid && advance) begin
      if (dec_update.latch_we) begin
        state.bank_latch <= dec_update.latch_value;
      end
      if (dec_update.port_we) begin
        state.flat_bank     <= dec_update.flat_bank;
        state.rom_paged_out <= dec_update.rom_paged_out;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_target <= dec_target;
      out_phys   <= dec_phys;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_target;
  assign m_tdata  = {{(bmd_pkg::OutDataW - bmd_pkg::PhysW){1'b0}}, out_phys};

endmodule

`default_nettype wire

/* rtl/core/bmd_decode.sv */
`default_nettype none

module bmd_decode (
  input  wire logic                              latch_mode,
  input  wire bmd_pkg::bank_state_t              state,
  input  wire bmd_pkg::cmd_t                     cmd,
  input  wire logic [bmd_pkg::AddrW-1:0]         addr,
  input  wire logic [bmd_pkg::ByteW-1:0]         wdata,
  input  wire logic [bmd_pkg::ByteW-1:0]         port_a,
  output bmd_pkg::target_t                       target,
  output logic      [bmd_pkg::PhysW-1:0]         phys_addr,
  output bmd_pkg::bank_update_t                  update
);

  logic is_bus;
  logic wr;

  assign is_bus = (cmd == bmd_pkg::CMD_READ) || (cmd == bmd_pkg::CMD_WRITE);
  assign wr     = (cmd == bmd_pkg::CMD_WRITE);

  // address decode for both banking modes
  always_comb begin
    target    = bmd_pkg::TGT_NONE;
    phys_addr = '0;
    if (is_bus) begin
      if (latch_mode) begin
        priority if (addr >= bmd_pkg::LatchBase) begin
          if (wr) begin
            target = bmd_pkg::TGT_LATCH;
          end else begin
            target    = bmd_pkg::TGT_ROM;
            phys_addr = {8'd0, addr[10:0]};
          end
        end else if (addr >= bmd_pkg::IoBase) begin
          target    = bmd_pkg::TGT_IO;
          phys_addr = {15'd0, addr[3:0]};
        end else if (addr[15]) begin
          target    = bmd_pkg::TGT_RAM;
          phys_addr = {state.bank_latch[7:4], addr[14:0]};
        end else begin
          target    = bmd_pkg::TGT_RAM;
          phys_addr = {state.bank_latch[3:0], addr[14:0]};
        end
      end else begin
        if ((addr >= bmd_pkg::RomBase) && !state.rom_paged_out) begin
          if (wr) begin
            target = bmd_pkg::TGT_ROMWR;
          end else begin
            target    = bmd_pkg::TGT_ROM;
            phys_addr = {5'd0, addr[13:0]};
          end
        end else begin
          target    = bmd_pkg::TGT_RAM;
          phys_addr = {state.flat_bank, addr};
        end
      end
    end
  end

  // state updates
  always_comb begin
    update.latch_we      = (target == bmd_pkg::TGT_LATCH);
    update.latch_value   = wdata;
    update.port_we       = (cmd == bmd_pkg::CMD_PORT);
    update.flat_bank     = port_a[6:4];
    update.rom_paged_out = port_a[3];
  end

endmodule

`default_nettype wire

/* rtl/core/bmd_checker.sv */
`default_nettype none

module bmd_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [bmd_pkg::OutDataW-1:0]     m_tdata,
  input wire logic [bmd_pkg::TgtW-1:0]         m_tuser
);

  // no result word straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word shown after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // words without an address carry a zero offset
  a_zero_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bmd_pkg::TGT_NONE || m_tuser == bmd_pkg::TGT_LATCH ||
                 m_tuser == bmd_pkg::TGT_ROMWR) |-> m_tdata == '0)
    else $error("non-zero offset on an addressless target");

  // io offset is a register number and rom offset stays inside the rom
  a_io_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmd_pkg::TGT_IO |-> m_tdata[23:4] == '0)
    else $error("io offset out of range");

  a_rom_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == bmd_pkg::TGT_ROM |-> m_tdata[23:14] == '0)
    else $error("rom offset out of range");

endmodule

bind banked_memory_decoder_core bmd_checker u_bmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
